[hdl/foba_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// foba_pkg
// Shared types, constants and band edge tables of the octave band accumulator.
// ----------------------------------------------------------------------------
package foba_pkg;

  localparam int FRAME_BINS_DEF  = 1024;
  localparam int BIN_LIMIT_DEF   = 1000;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int CNT_W     = 11;
  localparam int BAND_W    = 5;
  localparam int CHAN_W    = 2;
  localparam int BIN_W     = 16;
  localparam int SUM_W     = 16;
  localparam int EDGE_W    = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [CNT_W-1:0]  CNT_MAX         = '1;
  localparam logic [BAND_W:0]   THIRD_BANDS     = 6'd20;
  localparam logic [BAND_W:0]   OCTAVE_BANDS    = 6'd10;
  localparam logic [SUM_W-1:0]  NOISE_FLOOR_RST = 16'd8;
  localparam logic [SUM_W-1:0]  SUM_MAX         = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENSOR_MODE = 2'd0,
    REG_NOISE_FLOOR = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    CMD_CLEAR = 1'b0,
    CMD_BIN   = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                kind;
    logic                     close;
    logic                     last;
    logic [BAND_W-1:0]        band;
    logic [CHAN_W-1:0]        chan;
    logic signed [BIN_W-1:0]  re;
    logic signed [BIN_W-1:0]  im;
  } cmd_t;

  function automatic logic [EDGE_W-1:0] third_edge(input logic [BAND_W-1:0] idx);
    logic [EDGE_W-1:0] e;
    case (idx)
      5'd0:  e = 10'd1;
      5'd1:  e = 10'd1;
      5'd2:  e = 10'd1;
      5'd3:  e = 10'd2;
      5'd4:  e = 10'd3;
      5'd5:  e = 10'd3;
      5'd6:  e = 10'd4;
      5'd7:  e = 10'd6;
      5'd8:  e = 10'd7;
      5'd9:  e = 10'd9;
      5'd10: e = 10'd12;
      5'd11: e = 10'd15;
      5'd12: e = 10'd19;
      5'd13: e = 10'd24;
      5'd14: e = 10'd31;
      5'd15: e = 10'd38;
      5'd16: e = 10'd49;
      5'd17: e = 10'd62;
      5'd18: e = 10'd79;
      5'd19: e = 10'd99;
      default: e = '0;
    endcase
    return e;
  endfunction

  function automatic logic [EDGE_W-1:0] octave_edge(input logic [BAND_W-1:0] idx);
    logic [EDGE_W-1:0] e;
    case (idx)
      5'd0:  e = 10'd1;
      5'd1:  e = 10'd2;
      5'd2:  e = 10'd4;
      5'd3:  e = 10'd8;
      5'd4:  e = 10'd17;
      5'd5:  e = 10'd35;
      5'd6:  e = 10'd68;
      5'd7:  e = 10'd137;
      5'd8:  e = 10'd275;
      5'd9:  e = 10'd550;
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

[hdl/foba_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// foba_front
// Bin counting, frame tracking and band closing; issues commands to the queue.
// ----------------------------------------------------------------------------
module foba_front #(
  parameter int FRAME_BINS = foba_pkg::FRAME_BINS_DEF,
  parameter int BIN_LIMIT  = foba_pkg::BIN_LIMIT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic [foba_pkg::CHAN_W-1:0]       channel_i,
  input  logic signed [foba_pkg::BIN_W-1:0] bin_real_i,
  input  logic signed [foba_pkg::BIN_W-1:0] bin_imag_i,
  input  logic                              first_bin_i,
  input  logic                              sensor_mode_i,
  output logic                              q_wr_o,
  output foba_pkg::cmd_t                    q_wdata_o
);

  logic [foba_pkg::CNT_W-1:0]  cnt_q, cnt_d, cnt_inc;
  logic [foba_pkg::BAND_W-1:0] band_q, band_d;
  logic                        fin_q, fin_d;
  logic [foba_pkg::BAND_W:0]   nbands;
  logic [foba_pkg::BAND_W:0]   band_nxt;
  logic [foba_pkg::EDGE_W-1:0] edge_bin;
  logic                        in_frame, close, last;

  always_comb begin
    cnt_inc  = (cnt_q == foba_pkg::CNT_MAX) ? cnt_q : cnt_q + 1'b1;
    in_frame = ({2'b00, cnt_inc} < 13'(FRAME_BINS));
    nbands   = sensor_mode_i ? foba_pkg::THIRD_BANDS : foba_pkg::OCTAVE_BANDS;
    band_nxt = {1'b0, band_q} + 1'b1;
    if ({1'b0, band_q} >= nbands) begin
      edge_bin = '0;
    end else if (sensor_mode_i) begin
      edge_bin = foba_pkg::third_edge(band_q);
    end else begin
      edge_bin = foba_pkg::octave_edge(band_q);
    end
    close = !(({1'b0, cnt_inc} < {2'b00, edge_bin}) &&
              ({1'b0, cnt_inc} < 12'(BIN_LIMIT)));
    last  = (band_nxt >= nbands);
  end

  always_comb begin
    cnt_d     = cnt_q;
    band_d    = band_q;
    fin_d     = fin_q;
    q_wr_o    = 1'b0;
    q_wdata_o = '{kind: foba_pkg::CMD_BIN, close: close, last: last, band: band_q,
                  chan: channel_i, re: bin_real_i, im: bin_imag_i};
    if (accept_i) begin
      if (first_bin_i) begin
        cnt_d          = '0;
        band_d         = '0;
        fin_d          = 1'b0;
        q_wr_o         = 1'b1;
        q_wdata_o.kind = foba_pkg::CMD_CLEAR;
      end else if (!fin_q) begin
        cnt_d = cnt_inc;
        if (in_frame) begin
          q_wr_o = 1'b1;
          if (close) begin
            if (last) begin
              fin_d = 1'b1;
            end else begin
              band_d = band_nxt[foba_pkg::BAND_W-1:0];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      band_q <= '0;
      fin_q  <= 1'b1;
    end else begin
      cnt_q  <= cnt_d;
      band_q <= band_d;
      fin_q  <= fin_d;
    end
  end

endmodule

[hdl/foba_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// foba_queue
// Command queue between front and back; read data is registered on pop.
// ----------------------------------------------------------------------------
module foba_queue #(
  parameter int DEPTH = foba_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  foba_pkg::cmd_t wdata_i,
  output logic           full_o,
  input  logic           rd_i,
  output logic           empty_o,
  output foba_pkg::cmd_t rdata_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  foba_pkg::cmd_t   mem [DEPTH];
  foba_pkg::cmd_t   rdata_q;
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_wr, do_rd;

  assign full_o  = (count_q == CNT_FULL);
  assign empty_o = (count_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = rdata_q;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_wr) begin
      wptr_d = (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;
    end
    if (do_rd) begin
      rptr_d = (rptr_q == PTR_LAST) ? '0 : rptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem[wptr_q] <= wdata_i;
    end
    if (do_rd) begin
      rdata_q <= mem[rptr_q];
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL) else $error("queue count beyond depth");
  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wptr_q == rptr_q)) else $error("empty queue with pointers apart");
  a_full_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == CNT_FULL) |-> (wptr_q == rptr_q)) else $error("full queue with pointers apart");

endmodule

[hdl/foba_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// foba_back
// Magnitude by iterative square root, band accumulation and result register.
// ----------------------------------------------------------------------------
module foba_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_empty_i,
  output logic                          q_rd_o,
  input  foba_pkg::cmd_t                q_rdata_i,
  input  logic [foba_pkg::SUM_W-1:0]    noise_floor_i,
  input  logic                          pop_i,
  output logic                          empty_o,
  output logic [foba_pkg::CHAN_W-1:0]   axis_o,
  output logic [foba_pkg::BAND_W-1:0]   band_index_o,
  output logic [foba_pkg::SUM_W-1:0]    band_sum_o,
  output logic                          last_band_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_LOAD   = 5'b00100,
    S_ROOT   = 5'b01000,
    S_ACC    = 5'b10000
  } state_e;

  state_e                      state_q, state_d;
  logic [31:0]                 sqa_q, sqb_q;
  logic [31:0]                 n_q, n_d, root_q, root_d, bit_q, bit_d, trial;
  logic [foba_pkg::SUM_W-1:0]  acc_q, acc_d, mag, acc_new;
  logic [foba_pkg::SUM_W:0]    acc_sum;
  logic                        ovalid_q, ovalid_d, can_emit, emit;
  logic signed [31:0]          prod_re, prod_im;

  assign prod_re  = q_rdata_i.re * q_rdata_i.re;
  assign prod_im  = q_rdata_i.im * q_rdata_i.im;
  assign trial    = root_q + bit_q;
  assign mag      = root_q[foba_pkg::SUM_W-1:0];
  assign acc_sum  = {1'b0, acc_q} + {1'b0, mag};
  assign can_emit = !ovalid_q || pop_i;
  assign empty_o  = !ovalid_q;

  always_comb begin
    acc_new = acc_q;
    if (mag > noise_floor_i) begin
      acc_new = acc_sum[foba_pkg::SUM_W] ? foba_pkg::SUM_MAX
                                         : acc_sum[foba_pkg::SUM_W-1:0];
    end
  end

  always_comb begin
    state_d  = state_q;
    n_d      = n_q;
    root_d   = root_q;
    bit_d    = bit_q;
    acc_d    = acc_q;
    ovalid_d = ovalid_q && !pop_i;
    q_rd_o   = 1'b0;
    emit     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          q_rd_o  = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (q_rdata_i.kind == foba_pkg::CMD_CLEAR) begin
          acc_d   = '0;
          state_d = S_IDLE;
        end else begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        n_d     = sqa_q + sqb_q;
        root_d  = '0;
        bit_d   = 32'h4000_0000;
        state_d = S_ROOT;
      end
      S_ROOT: begin
        if (n_q >= trial) begin
          n_d    = n_q - trial;
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q == 32'd1) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        if (!q_rdata_i.close) begin
          acc_d   = acc_new;
          state_d = S_IDLE;
        end else if (can_emit) begin
          emit     = 1'b1;
          ovalid_d = 1'b1;
          acc_d    = '0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      acc_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      acc_q    <= acc_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DECODE) begin
      sqa_q <= $unsigned(prod_re);
      sqb_q <= $unsigned(prod_im);
    end
    n_q    <= n_d;
    root_q <= root_d;
    bit_q  <= bit_d;
    if (emit) begin
      axis_o       <= q_rdata_i.chan;
      band_index_o <= q_rdata_i.band;
      band_sum_o   <= acc_new;
      last_band_o  <= q_rdata_i.last;
    end
  end

  a_load_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD) |=> (state_q == S_ROOT && root_q == '0 && bit_q == 32'h4000_0000))
    else $error("root not seeded on load");
  a_mag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC) |-> (root_q <= 32'd46340)) else $error("magnitude out of range");
  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> !empty_o) else $error("closed band not presented");
  a_wait_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC && q_rdata_i.close && !can_emit) |=> (state_q == S_ACC))
    else $error("band closed while result register busy");

endmodule

[hdl/fft_octave_band_accumulator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fft_octave_band_accumulator_top
// Octave and third-octave band sums over a stream of FFT bins.
// ----------------------------------------------------------------------------
// Channel   Handshake         Payload
// bins in   push / full       channel_i, bin_real_i, bin_imag_i, first_bin_i
// bands out empty / pop       axis_o, band_index_o, band_sum_o, last_band_o
// config    cfg_we_i          cfg_idx_i, cfg_data_i
//
// A bin inside the frame passes the back end in order: fetch, square,
// load, 16 square root steps, accumulate. A first bin only fetches and clears; ignored bins skip it.
// The front takes one item per cycle until the command queue fills.
// Reset clears counters and queue and empties the result register; noise floor resets to 8.
// A closing band waits while the result register holds an untaken result.
// ----------------------------------------------------------------------------
module fft_octave_band_accumulator_top #(
  parameter int FRAME_BINS  = foba_pkg::FRAME_BINS_DEF,
  parameter int BIN_LIMIT   = foba_pkg::BIN_LIMIT_DEF,
  parameter int QUEUE_DEPTH = foba_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  output logic                                 full,
  input  logic [foba_pkg::CHAN_W-1:0]          channel_i,
  input  logic signed [foba_pkg::BIN_W-1:0]    bin_real_i,
  input  logic signed [foba_pkg::BIN_W-1:0]    bin_imag_i,
  input  logic                                 first_bin_i,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [foba_pkg::CHAN_W-1:0]          axis_o,
  output logic [foba_pkg::BAND_W-1:0]          band_index_o,
  output logic [foba_pkg::SUM_W-1:0]           band_sum_o,
  output logic                                 last_band_o,
  input  logic                                 cfg_we_i,
  input  logic [foba_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [foba_pkg::CFG_DAT_W-1:0]       cfg_data_i
);

  logic                       sensor_mode_q;
  logic [foba_pkg::SUM_W-1:0] noise_floor_q;
  logic                       q_wr, q_rd, q_empty;
  foba_pkg::cmd_t             q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sensor_mode_q <= 1'b0;
      noise_floor_q <= foba_pkg::NOISE_FLOOR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        foba_pkg::REG_SENSOR_MODE: sensor_mode_q <= cfg_data_i[0];
        foba_pkg::REG_NOISE_FLOOR: noise_floor_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  foba_front #(
    .FRAME_BINS (FRAME_BINS),
    .BIN_LIMIT  (BIN_LIMIT)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (push && !full),
    .channel_i     (channel_i),
    .bin_real_i    (bin_real_i),
    .bin_imag_i    (bin_imag_i),
    .first_bin_i   (first_bin_i),
    .sensor_mode_i (sensor_mode_q),
    .q_wr_o        (q_wr),
    .q_wdata_o     (q_wdata)
  );

  foba_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (q_wdata),
    .full_o  (full),
    .rd_i    (q_rd),
    .empty_o (q_empty),
    .rdata_o (q_rdata)
  );

  foba_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_rd_o        (q_rd),
    .q_rdata_i     (q_rdata),
    .noise_floor_i (noise_floor_q),
    .pop_i         (pop),
    .empty_o       (empty),
    .axis_o        (axis_o),
    .band_index_o  (band_index_o),
    .band_sum_o    (band_sum_o),
    .last_band_o   (last_band_o)
  );

endmodule

[bench/tb_fft_octave_band_accumulator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fft_octave_band_accumulator_top
// Self-checking bench for the octave band accumulator. Streams of FFT bins
// (directed corner values, then randomized frames with restarts and strays)
// go in under random push gaps and pop stalls. A scoreboard recomputes every
// band sum from the accepted bins and checks each popped result in order.
// ----------------------------------------------------------------------------
module tb_fft_octave_band_accumulator_top;

  localparam int CHAN_W      = foba_pkg::CHAN_W;
  localparam int BIN_W       = foba_pkg::BIN_W;
  localparam int BAND_W      = foba_pkg::BAND_W;
  localparam int SUM_W       = foba_pkg::SUM_W;
  localparam int CFG_IDX_W   = foba_pkg::CFG_IDX_W;
  localparam int CFG_DAT_W   = foba_pkg::CFG_DAT_W;

  localparam int FRAME_LEN   = 1024;
  localparam int LAST_BIN    = 1000;
  localparam int SETTLE_CYC  = 200;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 8;
  localparam int PHASE_BINS  = 130;

  typedef struct packed {
    logic [CHAN_W-1:0]       chan;
    logic signed [BIN_W-1:0] re;
    logic signed [BIN_W-1:0] im;
    logic                    is_first;
  } bin_t;

  typedef struct packed {
    logic [CHAN_W-1:0] axis;
    logic [BAND_W-1:0] band;
    logic [SUM_W-1:0]  band_sum;
    logic              is_last;
  } band_t;

  class band_sum_scoreboard;
    logic             mode;
    logic [SUM_W-1:0] noise_lvl;
    int               bin_cnt;
    int               band_no;
    int               band_acc;
    bit               frame_done;
    int               third_bin[20];
    int               octave_bin[10];
    band_t            sums_due[$];
    int               errors;
    int               bins_used;
    int               bins_ignored;
    int               bands_seen;
    int               reg_writes;

    function new();
      third_bin  = '{1, 1, 1, 2, 3, 3, 4, 6, 7, 9, 12, 15, 19, 24, 31, 38, 49, 62, 79, 99};
      octave_bin = '{1, 2, 4, 8, 17, 35, 68, 137, 275, 550};
      mode       = 1'b0;
      noise_lvl  = 16'd8;
      bin_cnt    = 0;
      band_no    = 0;
      band_acc   = 0;
      frame_done = 1'b1;
    endfunction

    function void write_reg(foba_pkg::cfg_reg_e idx, logic [CFG_DAT_W-1:0] data);
      reg_writes++;
      case (idx)
        foba_pkg::REG_SENSOR_MODE: mode = data[0];
        foba_pkg::REG_NOISE_FLOOR: noise_lvl = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return sums_due.size();
    endfunction

    function void accept_bin(bin_t b);
      logic [31:0] power;
      logic [15:0] mag;
      logic [15:0] trial;
      int          nbands;
      int          close_bin;
      bit          is_last;
      if (b.is_first) begin
        bin_cnt    = 0;
        band_no    = 0;
        band_acc   = 0;
        frame_done = 1'b0;
        bins_used++;
        return;
      end
      if (frame_done) begin
        bins_ignored++;
        return;
      end
      if (bin_cnt < 2047) bin_cnt++;
      if (bin_cnt >= FRAME_LEN) begin
        bins_ignored++;
        return;
      end
      bins_used++;
      power = 32'(int'($signed(b.re)) * int'($signed(b.re)))
            + 32'(int'($signed(b.im)) * int'($signed(b.im)));
      mag = '0;
      for (int k = 15; k >= 0; k--) begin
        trial = mag | (16'd1 << k);
        if (64'(trial) * 64'(trial) <= 64'(power)) mag = trial;
      end
      if (mag > noise_lvl) begin
        band_acc += int'(mag);
        if (band_acc > 65535) band_acc = 65535;
      end
      nbands = mode ? 20 : 10;
      if (band_no >= nbands) close_bin = 0;
      else close_bin = mode ? third_bin[band_no] : octave_bin[band_no];
      if (bin_cnt < close_bin && bin_cnt < LAST_BIN) return;
      is_last = (band_no + 1 >= nbands);
      sums_due.push_back('{b.chan, BAND_W'(band_no), SUM_W'(band_acc), is_last});
      band_acc = 0;
      if (is_last) frame_done = 1'b1;
      else band_no++;
    endfunction

    function void check_band(band_t got);
      band_t want;
      bands_seen++;
      if (sums_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected band result: axis %0d band %0d sum %0d last %0d",
                 $time, got.axis, got.band, got.band_sum, got.is_last);
        return;
      end
      want = sums_due.pop_front();
      if (got.axis !== want.axis) begin
        errors++;
        $display("%0t: axis mismatch: expected %0d, actual %0d", $time, want.axis, got.axis);
      end
      if (got.band !== want.band) begin
        errors++;
        $display("%0t: band_index mismatch: expected %0d, actual %0d",
                 $time, want.band, got.band);
      end
      if (got.band_sum !== want.band_sum) begin
        errors++;
        $display("%0t: band_sum mismatch: expected %0d, actual %0d",
                 $time, want.band_sum, got.band_sum);
      end
      if (got.is_last !== want.is_last) begin
        errors++;
        $display("%0t: last_band mismatch: expected %0d, actual %0d",
                 $time, want.is_last, got.is_last);
      end
    endfunction
  endclass

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    push        = 1'b0;
  logic                    full;
  logic [CHAN_W-1:0]       channel_i   = '0;
  logic signed [BIN_W-1:0] bin_real_i  = '0;
  logic signed [BIN_W-1:0] bin_imag_i  = '0;
  logic                    first_bin_i = 1'b0;
  logic                    empty;
  logic                    pop         = 1'b0;
  logic [CHAN_W-1:0]       axis_o;
  logic [BAND_W-1:0]       band_index_o;
  logic [SUM_W-1:0]        band_sum_o;
  logic                    last_band_o;
  logic                    cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i   = '0;
  logic [CFG_DAT_W-1:0]    cfg_data_i  = '0;

  band_sum_scoreboard sb = new();
  bit                 idling = 1'b1;
  int                 pop_hold = 0;
  int                 cycles = 0;
  int                 frame_left = 0;

  fft_octave_band_accumulator_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .channel_i    (channel_i),
    .bin_real_i   (bin_real_i),
    .bin_imag_i   (bin_imag_i),
    .first_bin_i  (first_bin_i),
    .empty        (empty),
    .pop          (pop),
    .axis_o       (axis_o),
    .band_index_o (band_index_o),
    .band_sum_o   (band_sum_o),
    .last_band_o  (last_band_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (pop_hold > 0) begin
      pop_hold <= pop_hold - 1;
      pop      <= 1'b0;
    end else if (idling && $urandom_range(0, 9) == 0) begin
      pop_hold <= $urandom_range(0, 14);
      pop      <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      sb.check_band('{axis_o, band_index_o, band_sum_o, last_band_o});
    end
  end

  function automatic logic [BIN_W-1:0] bin_part();
    case ($urandom_range(0, 5))
      0: return BIN_W'($urandom_range(0, 65535));
      1: return BIN_W'(int'($urandom_range(0, 40)) - 20);
      2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      default: return BIN_W'(int'($urandom_range(0, 6000)) - 3000);
    endcase
  endfunction

  // Frames continue across setting changes, so a mode switch lands mid-frame.
  function automatic bin_t next_bin();
    bin_t b;
    int   pick;
    b.chan     = CHAN_W'($urandom_range(0, 3));
    b.re       = bin_part();
    b.im       = bin_part();
    b.is_first = 1'b0;
    if (frame_left == 0) begin
      b.is_first = 1'b1;
      pick = $urandom_range(0, 9);
      if (sb.mode) begin
        if (pick < 6) frame_left = 99 + $urandom_range(0, 4);
        else if (pick < 9) frame_left = $urandom_range(1, 98);
        else frame_left = 0;
      end else begin
        if (pick < 3) frame_left = 550 + $urandom_range(0, 3);
        else frame_left = $urandom_range(1, 140);
      end
    end else begin
      frame_left--;
      if ($urandom_range(0, 199) == 0) b.is_first = 1'b1;
    end
    return b;
  endfunction

  task automatic send_bin(bin_t b);
    if (idling && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    push        <= 1'b1;
    channel_i   <= b.chan;
    bin_real_i  <= b.re;
    bin_imag_i  <= b.im;
    first_bin_i <= b.is_first;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.accept_bin(b);
  endtask

  task automatic configure(logic mode, logic [CFG_DAT_W-1:0] noise);
    logic [CFG_DAT_W-1:0] mode_word;
    mode_word = {15'($urandom), mode};
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= foba_pkg::REG_SENSOR_MODE;
    cfg_data_i <= mode_word;
    @(posedge clk_i);
    sb.write_reg(foba_pkg::REG_SENSOR_MODE, mode_word);
    cfg_idx_i  <= foba_pkg::REG_NOISE_FLOOR;
    cfg_data_i <= noise;
    @(posedge clk_i);
    sb.write_reg(foba_pkg::REG_NOISE_FLOOR, noise);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    bin_t                 opening[16];
    logic [CFG_DAT_W-1:0] noise;
    int                   target;
    opening = '{
      '{2'd1, 16'sh1234, 16'sh0000, 1'b0},
      '{2'd2, 16'shFFFF, 16'shFFFF, 1'b0},
      '{2'd3, 16'sh8000, 16'sh8000, 1'b1},
      '{2'd0, 16'sh8000, 16'sh8000, 1'b0},
      '{2'd1, 16'sh7FFF, 16'sh7FFF, 1'b0},
      '{2'd2, 16'sh0008, 16'sh0000, 1'b0},
      '{2'd3, 16'sh0000, 16'sh0009, 1'b0},
      '{2'd0, 16'sh8000, 16'sh0000, 1'b0},
      '{2'd0, 16'sh0000, 16'sh8000, 1'b0},
      '{2'd1, 16'sh7FFF, 16'sh8000, 1'b0},
      '{2'd2, 16'sh5555, 16'shAAAA, 1'b0},
      '{2'd1, 16'sh0000, 16'sh0000, 1'b1},
      '{2'd2, 16'sh0000, 16'sh0000, 1'b0},
      '{2'd0, 16'sh0003, 16'sh0004, 1'b0},
      '{2'd1, 16'shFFFA, 16'shFFF8, 1'b0},
      '{2'd3, 16'shAAAA, 16'sh5555, 1'b0}
    };
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening[i]) send_bin(opening[i]);
    frame_left = 5;

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: noise = 16'd0;
        1: noise = 16'hFFFF;
        2: noise = foba_pkg::NOISE_FLOOR_RST;
        default: noise = ($urandom_range(0, 3) == 0) ? CFG_DAT_W'($urandom)
                                                     : CFG_DAT_W'($urandom_range(0, 64));
      endcase
      configure(p % 2 == 0, noise);
      idling = (p != PHASES - 1);
      target = sb.bins_used + sb.bins_ignored + PHASE_BINS;
      while (sb.bins_used + sb.bins_ignored < target) send_bin(next_bin());
    end

    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);

    $display("Bins accepted: %0d processed, %0d dropped; band results checked: %0d",
             sb.bins_used, sb.bins_ignored, sb.bands_seen);
    $display("Register writes: %0d across octave and third-octave settings",
             sb.reg_writes);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/foba_pkg.sv
hdl/foba_front.sv
hdl/foba_queue.sv
hdl/foba_back.sv
hdl/fft_octave_band_accumulator_top.sv
bench/tb_fft_octave_band_accumulator_top.sv
